[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the probability map RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cbpm_pkg.sv]
// ---------------------------------------------------------------------------
// cbpm_pkg
// Constants and shared types of the context bit-probability map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbpm_pkg;

    // Configuration of the map
    localparam int CONTEXT_BITS = 8;
    localparam int INPUT_BITS   = 8;
    localparam int INIT_RATE    = 0;

    // Table geometry
    localparam int ROW_NODES  = (1 << INPUT_BITS) - 1;
    localparam int TABLE_SIZE = (1 << CONTEXT_BITS) * ROW_NODES;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int NODE_W     = INPUT_BITS;
    localparam int WALK_W     = $clog2(INPUT_BITS) + 1;

    // Slot layout and arithmetic widths
    localparam int WORD_W   = 32;
    localparam int CTX_W    = 32;
    localparam int CNT_W    = 10;
    localparam int PROB_W   = 22;
    localparam int PRED_W   = 12;
    localparam int RATE_W   = 13;
    localparam int ERR_W    = PROB_W + 2;
    localparam int SH_W     = ERR_W - 3;
    localparam int CNT_MAX  = 1023;
    localparam int DT_DEPTH = 1 << CNT_W;
    localparam int DT_NUM   = 16384;

    localparam logic [WORD_W-1:0] STEP_MASK = 32'hffff_fc00;
    localparam int                INIT_CNT  = (INIT_RATE > CNT_MAX) ? CNT_MAX : INIT_RATE;
    localparam logic [WORD_W-1:0] INIT_SLOT = 32'h8000_0000 | WORD_W'(INIT_CNT);

    // Configuration port
    localparam int              CFG_AW          = 3;
    localparam int              CFG_DW          = 32;
    localparam logic            REG_COUNT_LIMIT = 1'b0;
    localparam logic [CNT_W-1:0] LIMIT_RESET    = 10'd1023;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_wr;    // write reset value during the clearing pass
        logic ctx_load;  // take a new context
        logic rd_old;    // take a bit beat, read the slot predicted last
        logic look;      // capture old slot, rate and error
        logic mul;       // form the probability step
        logic wr_upd;    // write the updated slot, read the next slot
        logic finish;    // present the prediction, advance the walk
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
    } t_stat;

endpackage

`default_nettype wire

[hw/rtl/cbpm_ctrl.sv]
// ---------------------------------------------------------------------------
// cbpm_ctrl
// Sequencer of the probability map: clearing pass, then context loads and
// one update and one prediction per bit beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cbpm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_kind,
    input  wire cbpm_pkg::t_stat i_stat,
    output logic               o_busy,
    output logic               o_valid,
    output cbpm_pkg::t_cmd     o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_MUL   = 6'b001000,
        S_WR    = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Advance the sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start && i_kind) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK:  n_state = S_MUL;
            S_MUL:   n_state = S_WR;
            S_WR:    n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive commands and handshake
    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_wr   = (r_state == S_CLEAR);
        o_cmd.ctx_load = (r_state == S_IDLE) && i_start && !i_kind;
        o_cmd.rd_old   = (r_state == S_IDLE) && i_start && i_kind;
        o_cmd.look     = (r_state == S_LOOK);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.wr_upd   = (r_state == S_WR);
        o_cmd.finish   = (r_state == S_OUT);
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    `ASSERT_NEXT(a_clear_exit, i_clk, i_rst_n, (r_state == S_CLEAR) && i_stat.clr_done,
        r_state == S_IDLE, "clearing pass did not hand over to idle")
    `ASSERT_NEXT(a_bit_beat, i_clk, i_rst_n, i_start && !o_busy && i_kind,
        r_state == S_LOOK, "bit beat accepted without starting the update")
    `ASSERT_IMPL(a_cmd_excl, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd),
        "more than one datapath command at once")

endmodule

`default_nettype wire

[hw/rtl/cbpm_dpath.sv]
// ---------------------------------------------------------------------------
// cbpm_dpath
// Slot memory, rate table, update arithmetic and bit-tree walk state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cbpm_dpath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire cbpm_pkg::t_cmd                    i_cmd,
    input  wire logic [cbpm_pkg::CTX_W-1:0]        i_context_value,
    input  wire logic                              i_coded_bit,
    input  wire logic [cbpm_pkg::CNT_W-1:0]        i_count_limit,
    output cbpm_pkg::t_stat                        o_stat,
    output logic      [cbpm_pkg::PRED_W-1:0]       o_prediction
);

    localparam int WW = cbpm_pkg::WORD_W;
    localparam int SW = cbpm_pkg::SLOT_W;
    localparam int NW = cbpm_pkg::NODE_W;
    localparam int CW = cbpm_pkg::CNT_W;

    // Slot memory
    logic [WW-1:0] r_mem [cbpm_pkg::TABLE_SIZE];
    logic [WW-1:0] r_rd;
    logic [SW-1:0] w_raddr;
    logic [SW-1:0] w_waddr;
    logic [WW-1:0] w_wdata;
    logic          w_we;

    // Walk state
    logic [SW-1:0]                 r_row_base;
    logic [SW-1:0]                 r_last_slot;
    logic [NW-1:0]                 r_tree_node;
    logic [cbpm_pkg::WALK_W-1:0]   r_bits_done;
    logic [SW-1:0]                 r_clr_addr;

    // Update pipeline
    logic                            r_bit;
    logic [WW-1:0]                   r_s;
    logic                            r_inc;
    logic [cbpm_pkg::RATE_W-1:0]     r_rate;
    logic signed [cbpm_pkg::SH_W-1:0] r_sh;
    logic [WW-1:0]                   r_step;
    logic                            r_fwd;
    logic [WW-1:0]                   r_fwd_data;

    logic [cbpm_pkg::RATE_W-1:0]      w_dt [cbpm_pkg::DT_DEPTH];
    logic signed [cbpm_pkg::ERR_W-1:0] w_err;
    logic signed [WW+2:0]             w_prod;
    logic [WW-1:0]                    w_new;
    logic [NW-1:0]                    w_node_sel;
    logic [SW-1:0]                    w_next_slot;
    logic [cbpm_pkg::WALK_W-1:0]      w_bits_inc;
    logic [SW-1:0]                    w_row_new;

    // Rate table: dt[n] = 16384 / (2n + 3)
    for (genvar g = 0; g < cbpm_pkg::DT_DEPTH; g++) begin : g_dt
        localparam int Rate = cbpm_pkg::DT_NUM / (2 * g + 3);
        assign w_dt[g] = Rate[cbpm_pkg::RATE_W-1:0];
    end

    // Next slot of the walk, chosen by the coded bit
    assign w_node_sel  = (r_bit && (r_tree_node != '0)) ? r_tree_node + NW'(1) : r_tree_node;
    assign w_next_slot = r_row_base + SW'(w_node_sel);
    assign w_bits_inc  = r_bits_done + cbpm_pkg::WALK_W'(1);

    // Row base of a new context
    assign w_row_new = SW'(i_context_value[cbpm_pkg::CONTEXT_BITS-1:0])
                     * SW'(cbpm_pkg::ROW_NODES);

    // Error toward the coded bit, taken from the old slot on the read port
    assign w_err = $signed({1'b0, r_bit, {cbpm_pkg::PROB_W{1'b0}}})
                 - $signed({2'b00, r_rd[WW-1:CW]});
    assign w_prod = r_sh * $signed({1'b0, r_rate});
    assign w_new  = r_s + WW'(r_inc) + r_step;

    // Memory port selection
    assign w_raddr = i_cmd.wr_upd ? w_next_slot : r_last_slot;
    assign w_waddr = i_cmd.clr_wr ? r_clr_addr : r_last_slot;
    assign w_wdata = i_cmd.clr_wr ? cbpm_pkg::INIT_SLOT : w_new;
    assign w_we    = i_cmd.clr_wr || i_cmd.wr_upd;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + SW'(1);
        end
    end

    assign o_stat.clr_done = (r_clr_addr == SW'(cbpm_pkg::TABLE_SIZE - 1));

    // Hold the walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_base  <= '0;
            r_last_slot <= '0;
            r_tree_node <= '0;
            r_bits_done <= '0;
        end else if (i_cmd.ctx_load) begin
            r_row_base  <= w_row_new;
            r_tree_node <= '0;
            r_bits_done <= '0;
        end else if (i_cmd.finish) begin
            r_last_slot <= w_next_slot;
            if (w_bits_inc >= cbpm_pkg::WALK_W'(cbpm_pkg::INPUT_BITS)) begin
                r_bits_done <= '0;
                r_tree_node <= '0;
            end else begin
                r_bits_done <= w_bits_inc;
                r_tree_node <= {w_node_sel[NW-2:0], 1'b1};
            end
        end
    end

    // Update pipeline of the previous slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_old) begin
            r_bit <= i_coded_bit;
        end
        if (i_cmd.look) begin
            r_s    <= r_rd;
            r_inc  <= (r_rd[CW-1:0] < i_count_limit);
            r_rate <= w_dt[r_rd[CW-1:0]];
        end
        if (i_cmd.mul) begin
            r_step <= w_prod[WW-1:0] & cbpm_pkg::STEP_MASK;
        end
        if (i_cmd.wr_upd) begin
            r_fwd      <= (w_next_slot == r_last_slot);
            r_fwd_data <= w_new;
        end
    end

    // Scale the error down by eight beside the rate lookup
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_sh <= w_err[cbpm_pkg::ERR_W-1:3];
        end
    end

    // Prediction: top bits of the next slot, bypassed when it was just written
    assign o_prediction = r_fwd ? r_fwd_data[WW-1:WW-cbpm_pkg::PRED_W]
                                : r_rd[WW-1:WW-cbpm_pkg::PRED_W];

    `ASSERT_IMPL(a_clr_range, i_clk, i_rst_n, i_cmd.clr_wr,
        r_clr_addr < SW'(cbpm_pkg::TABLE_SIZE), "clearing address left the table")
    `ASSERT_IMPL(a_next_range, i_clk, i_rst_n, i_cmd.wr_upd,
        w_next_slot < SW'(cbpm_pkg::TABLE_SIZE), "next slot outside the table")
    `ASSERT_IMPL(a_walk_depth, i_clk, i_rst_n, 1'b1,
        r_bits_done < cbpm_pkg::WALK_W'(cbpm_pkg::INPUT_BITS), "walk ran past its depth")

endmodule

`default_nettype wire

[hw/rtl/context_bit_probability_map_unit.sv]
// ---------------------------------------------------------------------------
// context_bit_probability_map_unit
// Adaptive bit-probability table of a context-mixing coder, top level.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at a clock edge with start high and
//   busy low. kind 0 loads a new context (row of bit-tree nodes); busy
//   stays low. kind 1 carries the coded bit: the slot predicted last is
//   updated, then the walk steps down the tree.
//   Result channel: o_valid is high for one cycle with o_prediction, the
//   12-bit probability of a one for the next bit. The receiver takes it
//   in that cycle; there is no back-pressure.
//   Sequence: a bit beat holds busy through the update; o_valid rises in
//   its last state, and a new beat is taken only after busy falls again.
//   The steps follow from the slot memory, one read and one write per
//   cycle: read old slot, rate lookup, multiply, write back plus read
//   of the next slot.
//   Reset: synchronous, active low. A clearing pass then writes the reset
//   value into all 65280 slots, one per cycle; busy is high meanwhile.
//   Write the count limit over the APB port only while no bit beat is busy.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module context_bit_probability_map_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // command channel
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_kind,
    input  wire logic [cbpm_pkg::CTX_W-1:0]      i_context_value,
    input  wire logic                            i_coded_bit,
    // result channel
    output logic                                 o_valid,
    output logic      [cbpm_pkg::PRED_W-1:0]     o_prediction,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cbpm_pkg::CFG_AW-1:0]     paddr,
    input  wire logic [cbpm_pkg::CFG_DW-1:0]     pwdata,
    output logic      [cbpm_pkg::CFG_DW-1:0]     prdata,
    output logic                                 pready
);

    logic [cbpm_pkg::CNT_W-1:0] r_count_limit;
    logic                       w_reg_sel;
    cbpm_pkg::t_cmd             w_cmd;
    cbpm_pkg::t_stat            w_stat;

    // Register decode
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[cbpm_pkg::CFG_AW-1] == cbpm_pkg::REG_COUNT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_limit <= cbpm_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_count_limit <= pwdata[cbpm_pkg::CNT_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? cbpm_pkg::CFG_DW'(r_count_limit) : '0;

    // Sequencer
    cbpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    // Datapath
    cbpm_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_context_value (i_context_value),
        .i_coded_bit     (i_coded_bit),
        .i_count_limit   (r_count_limit),
        .o_stat          (w_stat),
        .o_prediction    (o_prediction)
    );

endmodule

`default_nettype wire
